### rtl/nfir_pkg.sv
// shared types and constants for the normalized fir filter
// no dependencies; imported by the cell, divider and top level

package nfir_pkg;

  localparam int MAX_TAPS    = 6;
  localparam int SAMPLE_BITS = 16;
  localparam int WEIGHT_BITS = 8;
  localparam int OUT_BITS    = SAMPLE_BITS;
  localparam int TAP_CNT_BITS = 3;
  localparam int PROD_BITS   = SAMPLE_BITS + WEIGHT_BITS;
  localparam int ACC_BITS    = PROD_BITS + $clog2(MAX_TAPS);
  localparam int WSUM_BITS   = WEIGHT_BITS + $clog2(MAX_TAPS);
  localparam int QCNT_BITS   = $clog2(SAMPLE_BITS);

  localparam int CFG_ADDR_BITS = 5;
  localparam int CFG_DATA_BITS = 32;
  localparam int REG_IDX_BITS  = 3;

  // register map, byte address is 4 * index
  localparam logic [REG_IDX_BITS-1:0] REG_TAP_COUNT = 3'd0;
  localparam logic [REG_IDX_BITS-1:0] REG_WEIGHT_0  = 3'd1;
  localparam logic [REG_IDX_BITS-1:0] REG_WEIGHT_5  = 3'd6;

  localparam logic [TAP_CNT_BITS-1:0] DEF_TAP_COUNT = 3'd4;
  localparam logic [WEIGHT_BITS-1:0]  DEF_WEIGHT_ON = 8'd1;

  typedef struct packed {
    logic shift;    // move the window one place, new sample into cell 0
    logic capture;  // register weight * sample in every cell
    logic clear;    // zero the sample window
  } cell_ctrl_t;

endpackage

### rtl/nfir_cell.sv
// one tap cell: holds a window sample, its product and the running sums
// depends on nfir_pkg

module nfir_cell import nfir_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  cell_ctrl_t             ctrl,
  input  logic                   active,
  input  logic [WEIGHT_BITS-1:0] weight,
  input  logic [SAMPLE_BITS-1:0] sample_in,
  input  logic [ACC_BITS-1:0]    psum_in,
  input  logic [WSUM_BITS-1:0]   wsum_in,
  output logic [SAMPLE_BITS-1:0] sample_out,
  output logic [ACC_BITS-1:0]    psum_out,
  output logic [WSUM_BITS-1:0]   wsum_out
);

  logic [SAMPLE_BITS-1:0] tap_r;
  logic [PROD_BITS-1:0]   prod_r;
  logic [PROD_BITS-1:0]   prod_nxt;
  logic [ACC_BITS-1:0]    psum_r;
  logic [WSUM_BITS-1:0]   wsum_r;

  assign prod_nxt = active ? (PROD_BITS'(weight) * PROD_BITS'(tap_r)) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tap_r <= '0;
    end else if (ctrl.clear) begin
      tap_r <= '0;
    end else if (ctrl.shift) begin
      tap_r <= sample_in;
    end
  end

  // sums ripple one cell per cycle; settled once the products hold still
  always_ff @(posedge clk) begin
    if (ctrl.capture) begin
      prod_r <= prod_nxt;
    end
    psum_r <= psum_in + ACC_BITS'(prod_r);
    wsum_r <= wsum_in + (active ? WSUM_BITS'(weight) : '0);
  end

  assign sample_out = tap_r;
  assign psum_out   = psum_r;
  assign wsum_out   = wsum_r;

endmodule

### rtl/nfir_div.sv
// restoring divider, one quotient bit per cycle, msb first
// depends on nfir_pkg; quotient fits SAMPLE_BITS since the result is an average

module nfir_div import nfir_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [ACC_BITS-1:0]    dividend,
  input  logic [WSUM_BITS-1:0]   divisor,
  output logic                   busy,
  output logic [SAMPLE_BITS-1:0] quotient
);

  logic                   busy_r;
  logic [QCNT_BITS-1:0]   cnt_r;
  logic [ACC_BITS-1:0]    rem_r;
  logic [WSUM_BITS-1:0]   div_r;
  logic [SAMPLE_BITS-1:0] q_r;
  logic [ACC_BITS-1:0]    trial;
  logic                   fits;

  assign trial = ACC_BITS'(div_r) << cnt_r;
  assign fits  = (rem_r >= trial);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= QCNT_BITS'(SAMPLE_BITS - 1);
    end else if (busy_r) begin
      if (cnt_r == '0) begin
        busy_r <= 1'b0;
      end else begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= dividend;
      div_r <= divisor;
    end else if (busy_r) begin
      if (fits) begin
        rem_r <= rem_r - trial;
      end
      q_r <= {q_r[SAMPLE_BITS-2:0], fits};
    end
  end

  assign busy     = busy_r;
  assign quotient = q_r;

  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r) else $error("divider started while busy");

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ($fell(busy_r) && div_r != '0) |-> (rem_r < ACC_BITS'(div_r)))
    else $error("remainder not below divisor after last step");

endmodule

### rtl/normalized_fir_filter_core.sv
// normalized fir filter top level: config registers, tap cell chain, divider
// depends on nfir_pkg, nfir_cell, nfir_div
// a new sample is accepted only once the previous result is in the output register
// it runs a multiply step, the 6-cell sum chain and the 16-step restoring divider
// a result waiting in the output register does not block the next input transfer
// reset (synchronous, rst_n low): window cleared, tap_count 4, weights 1,1,1,1,0,0

module normalized_fir_filter_core import nfir_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_tvalid,
  output logic                     in_tready,
  input  logic [15:0]              in_tdata,    // [15:0] sample
  input  logic                     in_tlast,    // last_sample
  output logic                     out_tvalid,
  input  logic                     out_tready,
  output logic [15:0]              out_tdata,   // [15:0] filtered_value
  output logic                     out_tuser,   // [0] zero_weight_sum
  input  logic                     cfg_psel,
  input  logic                     cfg_penable,
  input  logic                     cfg_pwrite,
  input  logic [CFG_ADDR_BITS-1:0] cfg_paddr,
  input  logic [CFG_DATA_BITS-1:0] cfg_pwdata,
  output logic [CFG_DATA_BITS-1:0] cfg_prdata,
  output logic                     cfg_pready
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MUL  = 4'b0010,
    ST_SUM  = 4'b0100,
    ST_DIV  = 4'b1000
  } state_t;

  localparam int SUM_CNT_BITS = $clog2(MAX_TAPS + 1);

  state_t                   state_r, state_nxt;
  logic [SUM_CNT_BITS-1:0]  cnt_r;
  logic                     last_r;
  logic                     zero_r;
  logic [TAP_CNT_BITS-1:0]  tap_count_r;
  logic [WEIGHT_BITS-1:0]   weight_r [MAX_TAPS];
  logic                     out_tvalid_r;
  logic [OUT_BITS-1:0]      out_tdata_r;
  logic                     out_tuser_r;

  logic                     in_xfer;
  logic                     cfg_wr;
  logic [REG_IDX_BITS-1:0]  reg_idx;
  logic                     div_start;
  logic                     div_busy;
  logic [SAMPLE_BITS-1:0]   div_q;
  logic                     out_load;
  cell_ctrl_t               cell_ctrl;

  logic [SAMPLE_BITS-1:0]   tap_w  [MAX_TAPS+1];
  logic [ACC_BITS-1:0]      psum_w [MAX_TAPS+1];
  logic [WSUM_BITS-1:0]     wsum_w [MAX_TAPS+1];

  // configuration port
  assign cfg_pready = 1'b1;
  assign reg_idx    = cfg_paddr[CFG_ADDR_BITS-1:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tap_count_r <= DEF_TAP_COUNT;
      for (int k = 0; k < MAX_TAPS; k++) begin
        weight_r[k] <= (k < int'(DEF_TAP_COUNT)) ? DEF_WEIGHT_ON : '0;
      end
    end else if (cfg_wr) begin
      unique case (reg_idx) inside
        REG_TAP_COUNT: tap_count_r <= cfg_pwdata[TAP_CNT_BITS-1:0];
        [REG_WEIGHT_0:REG_WEIGHT_5]: begin
          weight_r[reg_idx - REG_WEIGHT_0] <= cfg_pwdata[WEIGHT_BITS-1:0];
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx) inside
      REG_TAP_COUNT: cfg_prdata = CFG_DATA_BITS'(tap_count_r);
      [REG_WEIGHT_0:REG_WEIGHT_5]: begin
        cfg_prdata = CFG_DATA_BITS'(weight_r[reg_idx - REG_WEIGHT_0]);
      end
      default: cfg_prdata = '0;
    endcase
  end

  // sequencer
  assign in_tready = (state_r == ST_IDLE);
  assign in_xfer   = in_tvalid && in_tready;
  assign div_start = (state_r == ST_SUM) && (cnt_r == SUM_CNT_BITS'(MAX_TAPS));
  assign out_load  = (state_r == ST_DIV) && !div_busy && (!out_tvalid_r || out_tready);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_xfer) state_nxt = ST_MUL;
      ST_MUL:  state_nxt = ST_SUM;
      ST_SUM:  if (div_start) state_nxt = ST_DIV;
      ST_DIV:  if (out_load) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      last_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (in_xfer) begin
        last_r <= in_tlast;
      end
      if (state_r == ST_SUM) begin
        cnt_r <= cnt_r + 1'b1;
      end else begin
        cnt_r <= '0;
      end
    end
  end

  // products are taken from the window before it is cleared on a last item
  assign cell_ctrl.shift   = in_xfer;
  assign cell_ctrl.capture = (state_r == ST_MUL);
  assign cell_ctrl.clear   = (state_r == ST_MUL) && last_r;

  assign tap_w[0]  = in_tdata;
  assign psum_w[0] = '0;
  assign wsum_w[0] = '0;

  for (genvar k = 0; k < MAX_TAPS; k++) begin : g_cell
    nfir_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl       (cell_ctrl),
      .active     (tap_count_r > TAP_CNT_BITS'(k)),
      .weight     (weight_r[k]),
      .sample_in  (tap_w[k]),
      .psum_in    (psum_w[k]),
      .wsum_in    (wsum_w[k]),
      .sample_out (tap_w[k+1]),
      .psum_out   (psum_w[k+1]),
      .wsum_out   (wsum_w[k+1])
    );
  end

  nfir_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (psum_w[MAX_TAPS]),
    .divisor  (wsum_w[MAX_TAPS]),
    .busy     (div_busy),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (div_start) begin
      zero_r <= (wsum_w[MAX_TAPS] == '0);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (out_load) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_tdata_r <= zero_r ? '0 : div_q;
      out_tuser_r <= zero_r;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  a_zero_flag_value: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid_r && out_tuser_r) |-> (out_tdata_r == '0))
    else $error("zero weight sum flagged with nonzero value");

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> (state_r == ST_MUL && cell_ctrl.capture))
    else $error("accepted item did not start the multiply step");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV && !div_busy && out_tvalid_r && !out_tready)
    |=> (state_r == ST_DIV))
    else $error("result left the divider while the output was full");

  a_div_ready_at_start: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |=> div_busy)
    else $error("divider did not start with the sum");

endmodule

### tb/tb_normalized_fir_filter_core.sv
// self-checking testbench for normalized_fir_filter_core: weighted moving average over a sample
// stream, checked against an in-bench prediction of the window, weights and truncating divide
// depends on nfir_pkg and normalized_fir_filter_core

module tb_normalized_fir_filter_core;
  import nfir_pkg::*;

  localparam int LATENCY_CYCLES = 26;
  localparam int STALL_LIMIT    = 3000;
  localparam int HOLDOFF_CYCLES = 300;
  localparam int MAX_REPORTS    = 40;
  localparam logic [REG_IDX_BITS-1:0] REG_UNMAPPED = REG_WEIGHT_5 + 3'd1;

  typedef struct packed {
    logic [OUT_BITS-1:0] value;
    logic                zero_sum;
  } fir_result_t;

  typedef logic [MAX_TAPS-1:0][WEIGHT_BITS-1:0] weight_set_t;

  logic                     clk;
  logic                     rst_n;
  logic                     in_tvalid;
  logic                     in_tready;
  logic [15:0]              in_tdata;    // [15:0] sample
  logic                     in_tlast;    // last_sample
  logic                     out_tvalid;
  logic                     out_tready;
  logic [15:0]              out_tdata;   // [15:0] filtered_value
  logic                     out_tuser;   // [0] zero_weight_sum
  logic                     cfg_psel;
  logic                     cfg_penable;
  logic                     cfg_pwrite;
  logic [CFG_ADDR_BITS-1:0] cfg_paddr;
  logic [CFG_DATA_BITS-1:0] cfg_pwdata;
  logic [CFG_DATA_BITS-1:0] cfg_prdata;
  logic                     cfg_pready;

  // mirror of the filter state
  logic [TAP_CNT_BITS-1:0] tap_count_q;
  weight_set_t             weight_q;
  logic [SAMPLE_BITS-1:0]  window_q [MAX_TAPS-1];  // entry 0 is the previous sample
  fir_result_t             exp_avg_q [$];
  fir_result_t             check_want;

  int tx_idle_pct  = 0;
  int rx_idle_pct  = 0;
  int rx_hold_req  = 0;
  int rx_hold_left = 0;
  int idle_cycles  = 0;
  int mismatch_cnt = 0;

  normalized_fir_filter_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  function automatic fir_result_t weighted_average(input logic [SAMPLE_BITS-1:0] sample);
    int unsigned taps;
    int unsigned acc;
    int unsigned wsum;
    int unsigned quot;
    logic [SAMPLE_BITS-1:0] tap_sample;
    fir_result_t r;
    taps = (tap_count_q > MAX_TAPS) ? MAX_TAPS : tap_count_q;
    acc  = 0;
    wsum = 0;
    for (int k = 0; k < taps; k++) begin
      tap_sample = (k == 0) ? sample : window_q[k-1];
      acc  += weight_q[k] * tap_sample;
      wsum += weight_q[k];
    end
    if (wsum == 0) begin
      r.value    = '0;
      r.zero_sum = 1'b1;
    end else begin
      quot       = acc / wsum;
      r.value    = (quot > 32'hFFFF) ? 16'hFFFF : quot[15:0];
      r.zero_sum = 1'b0;
    end
    return r;
  endfunction

  task automatic advance_window(input logic [SAMPLE_BITS-1:0] sample, input logic last);
    if (last) begin
      foreach (window_q[k]) window_q[k] = '0;
    end else begin
      for (int k = MAX_TAPS - 2; k > 0; k--) window_q[k] = window_q[k-1];
      window_q[0] = sample;
    end
  endtask

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    mismatch_cnt++;
    if (mismatch_cnt <= MAX_REPORTS)
      $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $time);
  endtask

  task automatic send_sample(input logic [15:0] sample, input logic last);
    int gap;
    gap = 0;
    while (gap < 20 && $urandom_range(99) < tx_idle_pct) gap++;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= sample;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    exp_avg_q.push_back(weighted_average(sample));
    advance_window(sample, last);
  endtask

  // the loop waits on the clock before it checks the queue, so valid is never dropped and raised in one step
  task automatic wait_drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (exp_avg_q.size() != 0);
  endtask

  task automatic write_reg(input logic [REG_IDX_BITS-1:0] idx, input logic [31:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (idx == REG_TAP_COUNT)
      tap_count_q = value[TAP_CNT_BITS-1:0];
    else if (idx <= REG_WEIGHT_5)
      weight_q[idx - REG_WEIGHT_0] = value[WEIGHT_BITS-1:0];
  endtask

  // junk above the register width half of the time
  function automatic logic [31:0] with_noise(input logic [31:0] v, input int bits);
    return ($urandom_range(1) ? ($urandom() << bits) : 32'd0) | v;
  endfunction

  task automatic program_filter(input logic [TAP_CNT_BITS-1:0] taps, input weight_set_t w);
    wait_drain();
    repeat (LATENCY_CYCLES) @(posedge clk);
    write_reg(REG_TAP_COUNT, with_noise(taps, TAP_CNT_BITS));
    for (int k = 0; k < MAX_TAPS; k++)
      write_reg(REG_WEIGHT_0 + 3'(k), with_noise(w[k], WEIGHT_BITS));
    write_reg(REG_UNMAPPED, $urandom());
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [15:0] pick_sample();
    case ($urandom_range(9))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'($urandom_range(255));
      3:       return 16'hFF00 | 16'($urandom_range(255));
      default: return 16'($urandom());
    endcase
  endfunction

  function automatic logic [7:0] pick_weight();
    case ($urandom_range(7))
      0:       return 8'd0;
      1:       return 8'd255;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic weight_set_t pick_weights();
    weight_set_t w;
    w = '0;
    if ($urandom_range(9) != 0) begin
      for (int k = 0; k < MAX_TAPS; k++) w[k] = pick_weight();
    end
    return w;
  endfunction

  task automatic run_random_block(input int n_items);
    logic [TAP_CNT_BITS-1:0] taps;
    case ($urandom_range(9))
      0:       taps = 3'd0;
      1:       taps = 3'd7;
      default: taps = 3'($urandom_range(6, 1));
    endcase
    program_filter(taps, pick_weights());
    for (int i = 0; i < n_items; i++)
      send_sample(pick_sample(), $urandom_range(11) == 0);
  endtask

  // reset settings, windows filling up from zero and a restart after last
  task automatic test_reset_defaults();
    repeat (3) send_sample(16'hFFFF, 1'b0);
    send_sample(16'hFFFF, 1'b1);
    send_sample(16'hFFFF, 1'b0);
    send_sample(16'h0000, 1'b0);
  endtask

  task automatic test_config_extremes();
    program_filter(3'd6, {MAX_TAPS{8'hFF}});
    repeat (6) send_sample(16'hFFFF, 1'b0);
    send_sample(16'hFFFF, 1'b1);
    // no active taps
    program_filter(3'd0, {MAX_TAPS{8'hFF}});
    send_sample(16'h1234, 1'b0);
    send_sample(16'hFFFF, 1'b1);
    // tap count above the maximum
    program_filter(3'd7, {8'd6, 8'd5, 8'd4, 8'd3, 8'd2, 8'd1});
    send_sample(16'h8000, 1'b0);
    send_sample(16'h7FFF, 1'b0);
    send_sample(16'h0001, 1'b0);
    send_sample(16'h5555, 1'b1);
    program_filter(3'd6, '0);
    send_sample(16'hAAAA, 1'b0);
    send_sample(16'hFFFF, 1'b1);
    program_filter(3'd1, {8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd200});
    send_sample(16'hFFFF, 1'b0);
    send_sample(16'h0003, 1'b0);
  endtask

  task automatic test_random_traffic(input int tx_pct, input int rx_pct);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    repeat (5) run_random_block($urandom_range(140, 60));
  endtask

  // receiver holds off while the sender keeps offering, then the sender waits for all results
  task automatic test_backpressure();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    program_filter(3'd6, pick_weights());
    rx_hold_req = HOLDOFF_CYCLES;
    repeat (40) send_sample(pick_sample(), $urandom_range(15) == 0);
    wait_drain();
    repeat (10) send_sample(pick_sample(), 1'b0);
  endtask

  always @(posedge clk) begin
    if (rx_hold_req > 0) begin
      rx_hold_left = rx_hold_req;
      rx_hold_req  = 0;
    end
    if (rx_hold_left > 0) begin
      rx_hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (exp_avg_q.size() == 0) begin
        report_mismatch("unexpected result, filtered_value", out_tdata, 0);
      end else begin
        check_want = exp_avg_q.pop_front();
        if (out_tdata !== check_want.value)
          report_mismatch("filtered_value", out_tdata, check_want.value);
        if (out_tuser !== check_want.zero_sum)
          report_mismatch("zero_weight_sum", out_tuser, check_want.zero_sum);
      end
    end
  end

  // a run with no transfer for this long is hung
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("tb_normalized_fir_filter_core NOT OK");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_n       <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    in_tlast    <= 1'b0;
    out_tready  <= 1'b0;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    tap_count_q = DEF_TAP_COUNT;
    weight_q    = {8'd0, 8'd0, {4{DEF_WEIGHT_ON}}};
    foreach (window_q[k]) window_q[k] = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_config_extremes();
    test_random_traffic(20, 47);
    test_backpressure();
    test_random_traffic(47, 20);
    test_random_traffic(0, 0);

    wait_drain();
    repeat (2 * LATENCY_CYCLES) @(posedge clk);
    if (mismatch_cnt == 0 && exp_avg_q.size() == 0) begin
      $display("tb_normalized_fir_filter_core OK");
    end else begin
      $display("tb_normalized_fir_filter_core NOT OK");
    end
    $finish;
  end

endmodule
